/* rtl/ses_pkg.sv */
`timescale 1ns / 1ps

package ses_pkg;

    localparam int CFG_W   = 11;
    localparam int COORD_W = 10;
    localparam int PIX_W   = 8;
    localparam int DATA_W  = 24;

    localparam logic [PIX_W-1:0] FG_VALUE  = 8'hFF;
    localparam logic [1:0]       PATH_ENDS = 2'd2;
    localparam logic [1:0]       EP_SAT    = 2'd3;
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_PATH_OK   = 2'd0,
        STATUS_ISOLATED  = 2'd1,
        STATUS_BAD_COUNT = 2'd2
    } status_t;

    typedef struct packed {
        logic               isolated;
        logic [1:0]         endpoints;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] end_col;
    } stats_t;

    // Window layout: column slot k at bits 3k..3k+2, top pixel first; center at bit 4.
    function automatic stats_t judge(input logic [8:0] win, input stats_t st,
                                     input logic [COORD_W-1:0] row,
                                     input logic [COORD_W-1:0] col);
        logic       up;
        logic       dn;
        logic       lf;
        logic       rt;
        logic [3:0] n;
        stats_t     res;
        res = st;
        up  = win[3];
        dn  = win[5];
        lf  = win[1];
        rt  = win[7];
        n   = 4'(up) + 4'(dn) + 4'(lf) + 4'(rt)
            + 4'(win[0] & ~lf & ~up) + 4'(win[6] & ~rt & ~up)
            + 4'(win[2] & ~lf & ~dn) + 4'(win[8] & ~rt & ~dn);
        if (win[4] && !st.isolated)
        begin
            if (n == 4'd0)
            begin
                res.isolated = 1'b1;
            end
            else if (n == 4'd1)
            begin
                if (st.endpoints != EP_SAT)
                begin
                    res.endpoints = st.endpoints + 2'd1;
                end
                res.end_row = row;
                res.end_col = col;
            end
        end
        return res;
    endfunction

endpackage

/* rtl/ses_ram.sv */
`timescale 1ns / 1ps

module ses_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/skeleton_endpoint_scanner.sv */
`timescale 1ns / 1ps
// Channel    Direction  Payload (lowest bit first)
// s_axis     in         pixel[7:0]
// m_axis     out        status[1:0], endpoint_count[3:2], start_row[13:4], start_col[23:14]
// cfg        in         cfg_addr 0 frame_width, 1 frame_height; cfg_wdata 11 bits
//
// One pixel per cycle: a two-stage pipe (accept/read, then window update and write back)
// around one line memory holding the two rows above, forwarded on same-column reuse.
// At frame end the last row is swept through the memory read port; no pixel is accepted
// until the sweep has handed its summary to the result register.
// Reset is asynchronous; size registers reset to 1024, the line memory is not cleared.
// A held result does not stop the next frame from streaming in.

module skeleton_endpoint_scanner #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [ses_pkg::PIX_W-1:0] s_axis_tdata,   // pixel
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [ses_pkg::DATA_W-1:0] m_axis_tdata,  // status, endpoint_count, start_row, start_col
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [ses_pkg::CFG_W-1:0] cfg_wdata
);

    import ses_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int RMPW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_TAIL,
        S_OUT
    } fl_state_t;

    // configuration
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;

    // input position
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // window stage
    logic          b_valid_reg, b_valid_next;
    logic          b_pix_reg, b_pix_next;
    logic [CW-1:0] b_col_reg, b_col_next;
    logic [RW-1:0] b_row_reg, b_row_next;
    logic          b_row_end_reg, b_row_end_next;
    logic          b_frame_end_reg, b_frame_end_next;
    logic [8:0]    win_reg, win_next;

    // forwarding of last write
    logic          fwd_valid_reg, fwd_valid_next;
    logic [CW-1:0] fwd_addr_reg, fwd_addr_next;
    logic [1:0]    fwd_data_reg, fwd_data_next;

    // frame statistics
    stats_t st_reg, st_next;

    // last-row sweep
    fl_state_t     fl_state_reg, fl_state_next;
    logic [CW-1:0] fl_addr_reg, fl_addr_next;
    logic [CW-1:0] fl_last_reg, fl_last_next;
    logic          fl_rge1_reg, fl_rge1_next;
    logic          fl_dv_reg, fl_dv_next;
    logic [CW-1:0] fl_pidx_reg, fl_pidx_next;
    logic [8:0]    fl_win_reg, fl_win_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;

    logic            accept;
    logic            fl_issue;
    logic            mem_re;
    logic [CW-1:0]   mem_raddr;
    logic [1:0]      mem_rdata;
    logic            mem_we;
    logic [1:0]      mem_wdata;

    logic [CMPW-1:0] w_ext, w_eff, col_inc;
    logic [RMPW-1:0] h_ext, h_eff, row_inc;
    logic            row_end, frame_end;

    logic [1:0]         rd_col;
    logic               top_b, mid_b;
    logic [8:0]         win_base, win_b;
    stats_t             st_b1, st_b2;
    logic [COORD_W-1:0] row_above;
    logic [2:0]         fl_col;
    logic [8:0]         fl_win_in;
    stats_t             st_fl;
    logic               load;
    status_t            status;

    assign s_axis_tready = (fl_state_reg == S_IDLE) && !(b_valid_reg && b_frame_end_reg);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fl_issue      = (fl_state_reg == S_READ);
    assign mem_re        = accept || fl_issue;
    assign mem_raddr     = fl_issue ? fl_addr_reg : col_reg;

    // effective frame size and position advance
    always_comb
    begin
        w_ext = CMPW'(width_cfg_reg);
        h_ext = RMPW'(height_cfg_reg);
        if (w_ext == '0)
            w_eff = CMPW'(1);
        else if (w_ext > CMPW'(MAX_WIDTH))
            w_eff = CMPW'(MAX_WIDTH);
        else
            w_eff = w_ext;
        if (h_ext == '0)
            h_eff = RMPW'(1);
        else if (h_ext > RMPW'(MAX_HEIGHT))
            h_eff = RMPW'(MAX_HEIGHT);
        else
            h_eff = h_ext;
        col_inc   = CMPW'(col_reg) + CMPW'(1);
        row_inc   = RMPW'(row_reg) + RMPW'(1);
        row_end   = (col_inc >= w_eff);
        frame_end = row_end && (row_inc >= h_eff);
    end

    ses_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (b_col_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // window stage: bit 0 of a line entry is the upper row, bit 1 the middle row
    always_comb
    begin
        rd_col    = (fwd_valid_reg && fwd_addr_reg == b_col_reg) ? fwd_data_reg : mem_rdata;
        top_b     = (b_row_reg > RW'(1)) ? rd_col[0] : 1'b0;
        mid_b     = (b_row_reg != '0) ? rd_col[1] : 1'b0;
        win_base  = (b_col_reg == '0) ? 9'd0 : win_reg;
        win_b     = {b_pix_reg, mid_b, top_b, win_base[8:3]};
        row_above = COORD_W'(b_row_reg - RW'(1));
        if (b_row_reg != '0 && b_col_reg != '0)
            st_b1 = judge(win_b, st_reg, row_above, COORD_W'(b_col_reg - CW'(1)));
        else
            st_b1 = st_reg;
        // end of row: the last column of the row above has no right neighbor
        if (b_row_end_reg && b_row_reg != '0)
            st_b2 = judge({3'b000, win_b[8:3]}, st_b1, row_above, COORD_W'(b_col_reg));
        else
            st_b2 = st_b1;
        mem_we    = b_valid_reg;
        mem_wdata = {b_pix_reg, rd_col[1]};
    end

    // last-row sweep: bottom neighbors are outside the frame
    always_comb
    begin
        fl_col    = {1'b0, mem_rdata[1], fl_rge1_reg & mem_rdata[0]};
        fl_win_in = (fl_state_reg == S_TAIL) ? {3'b000, fl_win_reg[8:3]}
                                             : {fl_col, fl_win_reg[8:3]};
        if (fl_state_reg == S_TAIL)
            st_fl = judge(fl_win_in, st_reg, COORD_W'(b_row_reg), COORD_W'(fl_last_reg));
        else if (fl_pidx_reg != '0)
            st_fl = judge(fl_win_in, st_reg, COORD_W'(b_row_reg),
                          COORD_W'(fl_pidx_reg - CW'(1)));
        else
            st_fl = st_reg;
        load = (fl_state_reg == S_OUT) && (!m_valid_reg || m_axis_tready);
        if (st_reg.isolated)
            status = STATUS_ISOLATED;
        else if (st_reg.endpoints == PATH_ENDS)
            status = STATUS_PATH_OK;
        else
            status = STATUS_BAD_COUNT;
    end

    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        b_valid_next     = accept;
        b_pix_next       = b_pix_reg;
        b_col_next       = b_col_reg;
        b_row_next       = b_row_reg;
        b_row_end_next   = b_row_end_reg;
        b_frame_end_next = b_frame_end_reg;
        win_next         = win_reg;
        fwd_valid_next   = b_valid_reg;
        fwd_addr_next    = b_col_reg;
        fwd_data_next    = mem_wdata;
        st_next          = st_reg;
        fl_state_next    = fl_state_reg;
        fl_addr_next     = fl_addr_reg;
        fl_last_next     = fl_last_reg;
        fl_rge1_next     = fl_rge1_reg;
        fl_dv_next       = fl_issue;
        fl_pidx_next     = fl_addr_reg;
        fl_win_next      = fl_win_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_data_next      = m_data_reg;

        if (accept)
        begin
            b_pix_next       = (s_axis_tdata == FG_VALUE);
            b_col_next       = col_reg;
            b_row_next       = row_reg;
            b_row_end_next   = row_end;
            b_frame_end_next = frame_end;
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        if (b_valid_reg)
        begin
            win_next = win_b;
            st_next  = st_b2;
        end

        if (fl_dv_reg || fl_state_reg == S_TAIL)
        begin
            fl_win_next = fl_win_in;
            st_next     = st_fl;
        end

        case (fl_state_reg)
            S_IDLE:
            begin
                if (b_valid_reg && b_frame_end_reg)
                begin
                    fl_state_next = S_READ;
                    fl_addr_next  = '0;
                    fl_last_next  = b_col_reg;
                    fl_rge1_next  = (b_row_reg != '0);
                    fl_win_next   = '0;
                end
            end
            S_READ:
            begin
                if (fl_addr_reg == fl_last_reg)
                    fl_state_next = S_DRAIN;
                else
                    fl_addr_next = fl_addr_reg + CW'(1);
            end
            S_DRAIN:
            begin
                fl_state_next = S_TAIL;
            end
            S_TAIL:
            begin
                fl_state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load)
                begin
                    fl_state_next = S_IDLE;
                    m_valid_next  = 1'b1;
                    m_data_next   = {st_reg.end_col, st_reg.end_row, st_reg.endpoints, status};
                    st_next       = '0;
                end
            end
            default:
            begin
                fl_state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg   <= SIZE_RESET;
            height_cfg_reg  <= SIZE_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
            b_valid_reg     <= 1'b0;
            b_pix_reg       <= 1'b0;
            b_col_reg       <= '0;
            b_row_reg       <= '0;
            b_row_end_reg   <= 1'b0;
            b_frame_end_reg <= 1'b0;
            win_reg         <= '0;
            fwd_valid_reg   <= 1'b0;
            fwd_addr_reg    <= '0;
            fwd_data_reg    <= '0;
            st_reg          <= '0;
            fl_state_reg    <= S_IDLE;
            fl_addr_reg     <= '0;
            fl_last_reg     <= '0;
            fl_rge1_reg     <= 1'b0;
            fl_dv_reg       <= 1'b0;
            fl_pidx_reg     <= '0;
            fl_win_reg      <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_wdata;
                    REG_FRAME_HEIGHT: height_cfg_reg <= cfg_wdata;
                    default:          width_cfg_reg  <= width_cfg_reg;
                endcase
            end
            col_reg         <= col_next;
            row_reg         <= row_next;
            b_valid_reg     <= b_valid_next;
            b_pix_reg       <= b_pix_next;
            b_col_reg       <= b_col_next;
            b_row_reg       <= b_row_next;
            b_row_end_reg   <= b_row_end_next;
            b_frame_end_reg <= b_frame_end_next;
            win_reg         <= win_next;
            fwd_valid_reg   <= fwd_valid_next;
            fwd_addr_reg    <= fwd_addr_next;
            fwd_data_reg    <= fwd_data_next;
            st_reg          <= st_next;
            fl_state_reg    <= fl_state_next;
            fl_addr_reg     <= fl_addr_next;
            fl_last_reg     <= fl_last_next;
            fl_rge1_reg     <= fl_rge1_next;
            fl_dv_reg       <= fl_dv_next;
            fl_pidx_reg     <= fl_pidx_next;
            fl_win_reg      <= fl_win_next;
            m_valid_reg     <= m_valid_next;
            m_data_reg      <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // last pixel of a frame starts the sweep on the next cycle
    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_frame_end_reg |=> fl_state_reg == S_READ)
        else $error("sweep did not start after frame end");

    // sweep reads stay within the last row
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fl_issue |-> fl_addr_reg <= fl_last_reg)
        else $error("sweep address beyond last column");

    // pixel reads and sweep reads never share the port
    a_port_share: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && fl_issue))
        else $error("line memory read port conflict");

    // once an isolated point is seen, the endpoint count and end row hold until the result is taken
    a_iso_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.isolated && !load |=> $stable(st_reg.endpoints) && $stable(st_reg.end_row))
        else $error("endpoint record changed after isolated point");
`endif

endmodule

/* bench/tb_skeleton_endpoint_scanner.sv */
`timescale 1ns / 1ps

module tb_skeleton_endpoint_scanner;

    import ses_pkg::*;

    localparam int MAX_COLS       = 1024;
    localparam int MAX_ROWS       = 1024;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int IDLE_LIMIT     = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 32;

    typedef struct packed {
        status_t            status;
        logic [1:0]         count;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } frame_summary_t;

    // one hand-made frame; want is used only where typed is set
    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [8:0]       fg_mask;   // bit k set: raster pixel k is foreground
        logic [PIX_W-1:0] bg;
        logic             typed;
        frame_summary_t   want;
    } probe_frame_t;

    localparam int N_PROBES = 8;

    probe_frame_t probes [0:N_PROBES-1] = '{
        '{11'd1, 11'd1, 9'b000000001, 8'h00, 1'b1, '{STATUS_ISOLATED,  2'd0, 10'd0, 10'd0}},
        '{11'd1, 11'd1, 9'b000000000, 8'h00, 1'b1, '{STATUS_BAD_COUNT, 2'd0, 10'd0, 10'd0}},
        // zero sizes act as one
        '{11'd0, 11'd0, 9'b000000000, 8'hFE, 1'b1, '{STATUS_BAD_COUNT, 2'd0, 10'd0, 10'd0}},
        '{11'd2, 11'd1, 9'b000000011, 8'h00, 1'b1, '{STATUS_PATH_OK,   2'd2, 10'd0, 10'd1}},
        // four endpoints, count saturates
        '{11'd5, 11'd1, 9'b000011011, 8'h7F, 1'b1, '{STATUS_BAD_COUNT, 2'd3, 10'd0, 10'd4}},
        // isolated pixel first, later endpoints are frozen out
        '{11'd4, 11'd1, 9'b000001101, 8'h80, 1'b1, '{STATUS_ISOLATED,  2'd0, 10'd0, 10'd0}},
        '{11'd3, 11'd3, 9'b100010001, 8'h55, 1'b1, '{STATUS_PATH_OK,   2'd2, 10'd2, 10'd2}},
        // corner: diagonals masked by the orthogonal pixels
        '{11'd2, 11'd2, 9'b000001011, 8'hAA, 1'b0, '0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [PIX_W-1:0]    s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                cfg_we;
    logic                cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;

    frame_summary_t      pending_summaries [$];
    int unsigned         error_count  = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         burst_left   = 0;
    bit                  holdoff_req  = 1'b0;
    bit                  typed_on     = 1'b0;
    frame_summary_t      typed_want   = '0;

    // scanner state as the predictor sees it
    logic [CFG_W-1:0]    width_reg  = SIZE_RESET;
    logic [CFG_W-1:0]    height_reg = SIZE_RESET;
    bit                  upper_row  [0:MAX_COLS-1];
    bit                  middle_row [0:MAX_COLS-1];
    logic [8:0]          win_bits;
    int unsigned         scan_row;
    int unsigned         scan_col;
    logic [1:0]          ends_found;
    logic [COORD_W-1:0]  end_row;
    logic [COORD_W-1:0]  end_col;
    bit                  lone_seen;

    skeleton_endpoint_scanner #(
        .MAX_WIDTH  (MAX_COLS),
        .MAX_HEIGHT (MAX_ROWS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int fit_size(input logic [CFG_W-1:0] v, input int limit);
        if (v == '0)
            return 1;
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    function automatic int clip(input int v, input int n);
        return (v < 0) ? 0 : ((v >= n) ? n - 1 : v);
    endfunction

    function automatic void restart_frame();
        win_bits   = '0;
        scan_row   = 0;
        scan_col   = 0;
        ends_found = '0;
        end_row    = '0;
        end_col    = '0;
        lone_seen  = 1'b0;
    endfunction

    // classify the center of a window; window column k sits at bits 3k..3k+2, top first
    function automatic void tally(input logic [8:0] win, input int unsigned r,
                                  input int unsigned c);
        int unsigned n;
        logic        up;
        logic        dn;
        logic        lf;
        logic        rt;
        if (!win[4] || lone_seen)
            return;
        up = win[3];
        dn = win[5];
        lf = win[1];
        rt = win[7];
        n  = int'(up) + int'(dn) + int'(lf) + int'(rt);
        n += int'(win[0] && !lf && !up);
        n += int'(win[6] && !rt && !up);
        n += int'(win[2] && !lf && !dn);
        n += int'(win[8] && !rt && !dn);
        if (n == 0)
        begin
            lone_seen = 1'b1;
        end
        else if (n == 1)
        begin
            if (ends_found != EP_SAT)
                ends_found = ends_found + 2'd1;
            end_row = r[COORD_W-1:0];
            end_col = c[COORD_W-1:0];
        end
    endfunction

    // column j of the bottom row during the end-of-frame sweep; nothing below it
    function automatic logic [2:0] flush_column(input int j, input int last,
                                                input int unsigned r);
        if (j < 0 || j > last)
            return 3'b000;
        return {1'b0, middle_row[j], (r >= 1) ? upper_row[j] : 1'b0};
    endfunction

    function automatic bit scan_pixel(input logic [PIX_W-1:0] pix,
                                      output frame_summary_t sum);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int          j;
        bit          p;
        bit          top;
        bit          mid;
        w   = fit_size(width_reg, MAX_COLS);
        h   = fit_size(height_reg, MAX_ROWS);
        p   = (pix == FG_VALUE);
        r   = scan_row;
        c   = scan_col;
        sum = '0;
        top = (r >= 2) ? upper_row[c] : 1'b0;
        mid = (r >= 1) ? middle_row[c] : 1'b0;
        if (c == 0)
            win_bits = '0;
        win_bits = {p, mid, top, win_bits[8:3]};
        if (r >= 1 && c >= 1)
            tally(win_bits, r - 1, c - 1);
        upper_row[c]  = middle_row[c];
        middle_row[c] = p;
        if (c + 1 < w)
        begin
            scan_col = c + 1;
            return 1'b0;
        end
        // row done: the last column of the row above has no right neighbor
        if (r >= 1)
            tally({3'b000, win_bits[8:3]}, r - 1, c);
        if (r + 1 < h)
        begin
            scan_row = r + 1;
            scan_col = 0;
            return 1'b0;
        end
        for (j = 0; j <= int'(c); j++)
            tally({flush_column(j + 1, c, r), flush_column(j, c, r),
                   flush_column(j - 1, c, r)}, r, j);
        if (lone_seen)
            sum.status = STATUS_ISOLATED;
        else if (ends_found == PATH_ENDS)
            sum.status = STATUS_PATH_OK;
        else
            sum.status = STATUS_BAD_COUNT;
        sum.count = ends_found;
        sum.row   = end_row;
        sum.col   = end_col;
        restart_frame();
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        frame_summary_t sum;
        frame_summary_t want;
        logic [1:0]     got_status;
        logic [1:0]     got_count;
        logic [9:0]     got_row;
        logic [9:0]     got_col;
        if (!rst_n)
        begin
            width_reg  = SIZE_RESET;
            height_reg = SIZE_RESET;
            restart_frame();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_FRAME_WIDTH)
                    width_reg = cfg_wdata;
                else if (cfg_addr == REG_FRAME_HEIGHT)
                    height_reg = cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_status = m_axis_tdata[1:0];
                got_count  = m_axis_tdata[3:2];
                got_row    = m_axis_tdata[13:4];
                got_col    = m_axis_tdata[23:14];
                if (pending_summaries.size() == 0)
                begin
                    $error("summary transfer with no frame pending: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_summaries.pop_front();
                    if (got_status != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got_status);
                        error_count++;
                    end
                    if (got_count != want.count)
                    begin
                        $error("endpoint_count: expected %0d, got %0d", want.count, got_count);
                        error_count++;
                    end
                    if (got_row != want.row)
                    begin
                        $error("start_row: expected %0d, got %0d", want.row, got_row);
                        error_count++;
                    end
                    if (got_col != want.col)
                    begin
                        $error("start_col: expected %0d, got %0d", want.col, got_col);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (scan_pixel(s_axis_tdata, sum))
                    pending_summaries.push_back(typed_on ? typed_want : sum);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // summary side: spans of free flow, coin flips, a fixed duty pattern and near-stall
    initial
    begin : summary_pacing
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 64);
            for (k = 0; k < span; k++)
            begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (k % 5) < 2;
                    default: m_axis_tready <= ($urandom_range(0, 5) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] v);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_addr  <= REG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one frame holding a stroke, a straight line, noise, or an empty/full field
    task automatic send_skeleton(input int w, input int h);
        bit canvas [0:MAX_COLS-1];
        int style;
        int r;
        int c;
        int dr;
        int dc;
        int steps;
        int k;
        for (k = 0; k < MAX_COLS; k++)
            canvas[k] = 1'b0;
        style = $urandom_range(0, 9);
        r     = $urandom_range(0, h - 1);
        c     = $urandom_range(0, w - 1);
        if (style < 4)
        begin
            steps = $urandom_range(1, 2 * (w + h));
            repeat (steps)
            begin
                canvas[r * w + c] = 1'b1;
                r = clip(r + int'($urandom_range(0, 2)) - 1, h);
                c = clip(c + int'($urandom_range(0, 2)) - 1, w);
            end
        end
        else if (style < 7)
        begin
            dr = int'($urandom_range(0, 2)) - 1;
            dc = int'($urandom_range(0, 2)) - 1;
            if (dr == 0 && dc == 0)
                dc = 1;
            steps = $urandom_range(1, w + h);
            while (steps > 0 && r >= 0 && r < h && c >= 0 && c < w)
            begin
                canvas[r * w + c] = 1'b1;
                r += dr;
                c += dc;
                steps--;
            end
        end
        else if (style < 9)
        begin
            for (k = 0; k < w * h; k++)
                canvas[k] = ($urandom_range(0, 3) == 0);
        end
        else if ($urandom_range(0, 1) == 1)
        begin
            for (k = 0; k < w * h; k++)
                canvas[k] = 1'b1;
        end
        for (k = 0; k < w * h; k++)
            send_pixel(canvas[k] ? FG_VALUE : PIX_W'($urandom_range(0, 254)));
    endtask

    initial
    begin : stimulus
        int unsigned      ph;
        int unsigned      frames;
        int unsigned      n;
        int unsigned      k;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_FRAME_WIDTH;
        cfg_wdata     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_PROBES; i++)
        begin
            wait_idle();
            write_size(probes[i].width, probes[i].height);
            typed_on   = probes[i].typed;
            typed_want = probes[i].want;
            n = fit_size(probes[i].width, MAX_COLS) * fit_size(probes[i].height, MAX_ROWS);
            for (k = 0; k < n; k++)
                send_pixel(probes[i].fg_mask[k] ? FG_VALUE : probes[i].bg);
        end
        wait_idle();
        typed_on = 1'b0;

        for (ph = 0; ph < 17; ph++)
        begin
            frames = 4;
            if (ph == 2)
            begin
                // tiny frames while the summary side is held off: block backs up
                wv     = 11'd2;
                hv     = 11'd2;
                frames = 16;
            end
            else if (ph == 6)
            begin
                // one long row
                wv     = 11'd64;
                hv     = 11'd1;
                frames = 1;
            end
            else if (ph == 12)
            begin
                // one tall column
                wv     = 11'd1;
                hv     = 11'd64;
                frames = 1;
            end
            else
            begin
                wv = CFG_W'($urandom_range(0, 8));
                hv = CFG_W'($urandom_range(0, 8));
            end
            wait_idle();
            write_size(wv, hv);
            if (ph == 2)
                holdoff_req = 1'b1;
            repeat (frames) send_skeleton(fit_size(wv, MAX_COLS), fit_size(hv, MAX_ROWS));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_summaries.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/ses_pkg.sv
rtl/ses_ram.sv
rtl/skeleton_endpoint_scanner.sv
bench/tb_skeleton_endpoint_scanner.sv
